// ----- src/mdhp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and constants for the meter display pager.
package mdhp_pkg;

  localparam int CurW   = 16;
  localparam int VoltW  = 16;
  localparam int PowW   = 20;
  localparam int CntW   = 16;
  localparam int PageW  = 2;
  localparam int DbW    = 10;
  localparam int CstepW = 15;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int InDataW  = 56;
  localparam int OutDataW = 112;
  localparam int OutUserW = 2;

  localparam logic [PageW-1:0] PAGE_CURRENT = 2'd0;
  localparam logic [PageW-1:0] PAGE_VOLTAGE = 2'd1;
  localparam logic [PageW-1:0] PAGE_POWER   = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_DEADBAND        = 3'd1,
    REG_CURRENT_STEP    = 3'd2,
    REG_VOLTAGE_STEP    = 3'd3,
    REG_POWER_STEP      = 3'd4,
    REG_DWELL_CURRENT   = 3'd5,
    REG_DWELL_VOLTAGE   = 3'd6,
    REG_DWELL_POWER     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CntW-1:0]   sample_interval_ms;
    logic [DbW-1:0]    deadband_ma;
    logic [CstepW-1:0] current_step_ma;
    logic [VoltW-1:0]  voltage_step_mv;
    logic [PowW-1:0]   power_step_mw;
    logic [CntW-1:0]   dwell_current_ms;
    logic [CntW-1:0]   dwell_voltage_ms;
    logic [CntW-1:0]   dwell_power_ms;
  } cfg_t;

  typedef struct packed {
    logic [PowW-1:0]         sensed_power_mw;
    logic [VoltW-1:0]        sensed_voltage_mv;
    logic signed [CurW-1:0]  sensed_current_ma;
  } in_item_t;

  typedef struct packed {
    logic                    redraw_pulse;
    logic                    sample_strobe;
    logic [PowW-1:0]         live_power_mw;
    logic [VoltW-1:0]        live_voltage_mv;
    logic signed [CurW-1:0]  live_current_ma;
    logic [PowW-1:0]         held_power_mw;
    logic [VoltW-1:0]        held_voltage_mv;
    logic signed [CurW-1:0]  held_current_ma;
    logic [PageW-1:0]        page_shown;
  } result_t;

  typedef struct packed {
    logic [PageW-1:0] page_index;
    logic             redraw_pending;
  } status_t;

endpackage

// ----- src/mdhp_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file written through the configuration channel.
module mdhp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mdhp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mdhp_pkg::CfgDataW-1:0] cfg_data,
  output mdhp_pkg::cfg_t                cfg
);
  import mdhp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ms <= 16'd250;
      cfg.deadband_ma        <= 10'd2;
      cfg.current_step_ma    <= 15'd10;
      cfg.voltage_step_mv    <= 16'd10;
      cfg.power_step_mw      <= 20'd100;
      cfg.dwell_current_ms   <= 16'd6000;
      cfg.dwell_voltage_ms   <= 16'd2000;
      cfg.dwell_power_ms     <= 16'd2000;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SAMPLE_INTERVAL: cfg.sample_interval_ms <= cfg_data[CntW-1:0];
        REG_DEADBAND:        cfg.deadband_ma        <= cfg_data[DbW-1:0];
        REG_CURRENT_STEP:    cfg.current_step_ma    <= cfg_data[CstepW-1:0];
        REG_VOLTAGE_STEP:    cfg.voltage_step_mv    <= cfg_data[VoltW-1:0];
        REG_POWER_STEP:      cfg.power_step_mw      <= cfg_data[PowW-1:0];
        REG_DWELL_CURRENT:   cfg.dwell_current_ms   <= cfg_data[CntW-1:0];
        REG_DWELL_VOLTAGE:   cfg.dwell_voltage_ms   <= cfg_data[CntW-1:0];
        REG_DWELL_POWER:     cfg.dwell_power_ms     <= cfg_data[CntW-1:0];
      endcase
    end
  end

endmodule

// ----- src/mdhp_core.sv -----
`timescale 1ns / 1ps
// Sample latch, deadband, hysteresis hold and page rotation for one tick.
module mdhp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  mdhp_pkg::in_item_t item,
  input  mdhp_pkg::cfg_t     cfg,
  output mdhp_pkg::result_t  res,
  output mdhp_pkg::status_t  status
);
  import mdhp_pkg::*;

  logic [CntW-1:0]        sample_elapsed, sample_elapsed_next;
  logic [CntW-1:0]        page_elapsed, page_elapsed_next;
  logic [PageW-1:0]       page_index, page_index_next;
  logic signed [CurW-1:0] live_current, live_current_next;
  logic [VoltW-1:0]       live_voltage, live_voltage_next;
  logic [PowW-1:0]        live_power, live_power_next;
  logic signed [CurW-1:0] held_current, held_current_next;
  logic [VoltW-1:0]       held_voltage, held_voltage_next;
  logic [PowW-1:0]        held_power, held_power_next;
  logic                   redraw_pending;

  logic [CntW-1:0]        sample_inc, page_inc, dwell;
  logic                   sample_hit, page_hit;
  logic signed [CurW:0]   cur_ext;
  logic [CurW:0]          cur_mag;
  logic                   in_dead;
  logic signed [CurW:0]   cur_diff;
  logic [CurW:0]          cur_dist;
  logic signed [VoltW:0]  volt_diff;
  logic [VoltW:0]         volt_dist;
  logic signed [PowW:0]   pow_diff;
  logic [PowW:0]          pow_dist;
  logic                   upd_cur, upd_volt, upd_pow;

  always_comb begin
    sample_inc = (sample_elapsed == {CntW{1'b1}}) ? sample_elapsed : sample_elapsed + 16'd1;
    page_inc   = (page_elapsed == {CntW{1'b1}}) ? page_elapsed : page_elapsed + 16'd1;
    sample_hit = sample_inc >= cfg.sample_interval_ms;

    cur_ext = {item.sensed_current_ma[CurW-1], item.sensed_current_ma};
    cur_mag = cur_ext[CurW] ? (CurW+1)'(-cur_ext) : (CurW+1)'(cur_ext);
    in_dead = cur_mag < {{(CurW+1-DbW){1'b0}}, cfg.deadband_ma};

    if (sample_hit) begin
      live_current_next = in_dead ? '0 : item.sensed_current_ma;
      live_voltage_next = item.sensed_voltage_mv;
      live_power_next   = in_dead ? '0 : item.sensed_power_mw;
    end else begin
      live_current_next = live_current;
      live_voltage_next = live_voltage;
      live_power_next   = live_power;
    end

    cur_diff  = {live_current_next[CurW-1], live_current_next}
              - {held_current[CurW-1], held_current};
    cur_dist  = cur_diff[CurW] ? (CurW+1)'(-cur_diff) : (CurW+1)'(cur_diff);
    volt_diff = $signed({1'b0, live_voltage_next}) - $signed({1'b0, held_voltage});
    volt_dist = volt_diff[VoltW] ? (VoltW+1)'(-volt_diff) : (VoltW+1)'(volt_diff);
    pow_diff  = $signed({1'b0, live_power_next}) - $signed({1'b0, held_power});
    pow_dist  = pow_diff[PowW] ? (PowW+1)'(-pow_diff) : (PowW+1)'(pow_diff);

    upd_cur  = sample_hit && (cur_dist >= {{(CurW+1-CstepW){1'b0}}, cfg.current_step_ma});
    upd_volt = sample_hit && (volt_dist >= {1'b0, cfg.voltage_step_mv});
    upd_pow  = sample_hit && (pow_dist >= {1'b0, cfg.power_step_mw});

    unique case (page_index)
      PAGE_CURRENT: dwell = cfg.dwell_current_ms;
      PAGE_VOLTAGE: dwell = cfg.dwell_voltage_ms;
      default:      dwell = cfg.dwell_power_ms;
    endcase
    page_hit = page_inc >= dwell;

    sample_elapsed_next = sample_hit ? '0 : sample_inc;
    page_elapsed_next   = page_hit ? '0 : page_inc;
    if (page_hit) begin
      page_index_next   = (page_index >= PAGE_POWER) ? PAGE_CURRENT : page_index + 2'd1;
      held_current_next = live_current_next;
      held_voltage_next = live_voltage_next;
      held_power_next   = live_power_next;
    end else begin
      page_index_next   = page_index;
      held_current_next = upd_cur ? live_current_next : held_current;
      held_voltage_next = upd_volt ? live_voltage_next : held_voltage;
      held_power_next   = upd_pow ? live_power_next : held_power;
    end

    res.page_shown      = page_index_next;
    res.held_current_ma = held_current_next;
    res.held_voltage_mv = held_voltage_next;
    res.held_power_mw   = held_power_next;
    res.live_current_ma = live_current_next;
    res.live_voltage_mv = live_voltage_next;
    res.live_power_mw   = live_power_next;
    res.sample_strobe   = sample_hit;
    res.redraw_pulse    = redraw_pending || upd_cur || upd_volt || upd_pow || page_hit;

    status.page_index     = page_index;
    status.redraw_pending = redraw_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_elapsed <= '0;
      page_elapsed   <= '0;
      page_index     <= PAGE_CURRENT;
      live_current   <= '0;
      live_voltage   <= '0;
      live_power     <= '0;
      held_current   <= '0;
      held_voltage   <= '0;
      held_power     <= '0;
      redraw_pending <= 1'b1;
    end else if (advance) begin
      sample_elapsed <= sample_elapsed_next;
      page_elapsed   <= page_elapsed_next;
      page_index     <= page_index_next;
      live_current   <= live_current_next;
      live_voltage   <= live_voltage_next;
      live_power     <= live_power_next;
      held_current   <= held_current_next;
      held_voltage   <= held_voltage_next;
      held_power     <= held_power_next;
      redraw_pending <= 1'b0;
    end
  end

endmodule

// ----- src/meter_deadband_hysteresis_pager_unit.sv -----
`timescale 1ns / 1ps
// Top level of the meter display pager: input register, tick logic, result register.
//
//   channel   direction  beat                         handshake
//   s_axis    in         one tick of sensor readings  s_axis_tvalid / s_axis_tready
//   m_axis    out        one display result per tick  m_axis_tvalid / m_axis_tready
//   cfg       in         one register write           cfg_valid / cfg_ready
//
// Every tick passes the input register, then the tick logic and the result register,
// and one beat is taken per cycle while the result register is not stalled.
// Reset loads the register defaults, clears both stages and leaves a redraw pending.
// A stalled result register holds its beat; the input side keeps taking a beat while
// the input register is empty or moving on.
module meter_deadband_hysteresis_pager_unit (
  input  logic                           clk,
  input  logic                           rst,
  // current [15:0], voltage [31:16], power [51:32], zero [55:52]
  input  logic [mdhp_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // page [1:0], held current [17:2], held voltage [33:18], held power [53:34],
  // live current [69:54], live voltage [85:70], live power [105:86], zero [111:106]
  output logic [mdhp_pkg::OutDataW-1:0]  m_axis_tdata,
  // sample strobe [0], redraw pulse [1]
  output logic [mdhp_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mdhp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mdhp_pkg::CfgDataW-1:0]  cfg_data
);
  import mdhp_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_valid;
  logic     advance;
  result_t  core_res;
  status_t  core_status;
  result_t  out_res;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  mdhp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdhp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (core_res),
    .status  (core_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= in_item_t'(s_axis_tdata[PowW+VoltW+CurW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = {{(OutDataW-$bits(result_t)+OutUserW){1'b0}},
                         out_res[$bits(result_t)-OutUserW-1:0]};
  assign m_axis_tuser = {out_res.redraw_pulse, out_res.sample_strobe};

  property p_page_change_redraws;
    @(posedge clk) disable iff (rst)
      advance && (core_res.page_shown != core_status.page_index) |-> core_res.redraw_pulse;
  endproperty
  a_page_change_redraws: assert property (p_page_change_redraws)
    else $error("page changed without a redraw");

  property p_state_holds_when_idle;
    @(posedge clk) disable iff (rst)
      !advance |=> $stable(core_status.page_index);
  endproperty
  a_state_holds_when_idle: assert property (p_state_holds_when_idle)
    else $error("page moved without a tick");

  property p_redraw_pending_after_reset;
    @(posedge clk) $fell(rst) |-> core_status.redraw_pending;
  endproperty
  a_redraw_pending_after_reset: assert property (p_redraw_pending_after_reset)
    else $error("no redraw pending after reset");

  property p_pending_forces_pulse;
    @(posedge clk) disable iff (rst)
      advance && core_status.redraw_pending |-> core_res.redraw_pulse;
  endproperty
  a_pending_forces_pulse: assert property (p_pending_forces_pulse)
    else $error("pending redraw was not pulsed");

endmodule
